// ===== rtl/core/bmst_pkg.sv =====
package bmst_pkg;

    localparam logic [3:0] UNITS_MAX = 4'd9;
    localparam logic [2:0] TENS_MAX  = 3'd5;

    localparam logic OP_ADJUST = 1'b0;
    localparam logic OP_COUNT  = 1'b1;

    localparam logic [7:0] SEG_BLANK = 8'hFF;
    localparam logic [7:0] SEG_DOT_CLR = 8'hFE;

    typedef struct packed {
        logic       opcode;
        logic       count_up;
        logic [3:0] adjust_mask;
    } t_in_item;

    typedef struct packed {
        logic [3:0] sec_units;
        logic [2:0] sec_tens;
        logic [3:0] min_units;
        logic [2:0] min_tens;
        logic       at_zero;
        logic [7:0] seg_sec_units;
        logic [7:0] seg_sec_tens;
        logic [7:0] seg_min_units;
        logic [7:0] seg_min_tens;
    } t_out_item;

    typedef struct packed {
        logic [3:0] sec_units;
        logic [2:0] sec_tens;
        logic [3:0] min_units;
        logic [2:0] min_tens;
    } t_time;

    // active-low segments, bit 0 is the dot
    function automatic logic [7:0] f_seg(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'b0000_1001;
            4'd1:    s = 8'b1010_1111;
            4'd2:    s = 8'b0011_0001;
            4'd3:    s = 8'b0010_0011;
            4'd4:    s = 8'b1000_0111;
            4'd5:    s = 8'b0100_0011;
            4'd6:    s = 8'b0100_0001;
            4'd7:    s = 8'b0010_1111;
            4'd8:    s = 8'b0000_0001;
            4'd9:    s = 8'b0000_0111;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/core/bmst_step.sv =====
module bmst_step
    import bmst_pkg::*;
(
    input  t_time    i_time,
    input  t_in_item i_item,
    output t_time    o_time
);

    logic       su_top, st_top, mu_top;
    logic       su_zero, st_zero, mu_zero;
    logic [3:0] su_inc, mu_inc;
    logic [2:0] st_inc, mt_inc;
    logic [3:0] su_dec, mu_dec;
    logic [2:0] st_dec, mt_dec;

    always_comb begin
        // at or past the top the increment wraps to zero and carries
        su_top  = (i_time.sec_units >= UNITS_MAX);
        st_top  = (i_time.sec_tens  >= TENS_MAX);
        mu_top  = (i_time.min_units >= UNITS_MAX);
        su_zero = (i_time.sec_units == 4'd0);
        st_zero = (i_time.sec_tens  == 3'd0);
        mu_zero = (i_time.min_units == 4'd0);

        su_inc = su_top ? 4'd0 : i_time.sec_units + 4'd1;
        st_inc = st_top ? 3'd0 : i_time.sec_tens + 3'd1;
        mu_inc = mu_top ? 4'd0 : i_time.min_units + 4'd1;
        mt_inc = (i_time.min_tens >= TENS_MAX) ? 3'd0 : i_time.min_tens + 3'd1;

        su_dec = su_zero ? UNITS_MAX : i_time.sec_units - 4'd1;
        st_dec = st_zero ? TENS_MAX  : i_time.sec_tens - 3'd1;
        mu_dec = mu_zero ? UNITS_MAX : i_time.min_units - 4'd1;
        mt_dec = (i_time.min_tens == 3'd0) ? TENS_MAX : i_time.min_tens - 3'd1;

        o_time = i_time;
        if (i_item.opcode == OP_COUNT) begin
            if (i_item.count_up) begin
                o_time.sec_units = su_inc;
                if (su_top) begin
                    o_time.sec_tens = st_inc;
                    if (st_top) begin
                        o_time.min_units = mu_inc;
                        if (mu_top) begin
                            o_time.min_tens = mt_inc;
                        end
                    end
                end
            end else begin
                o_time.sec_units = su_dec;
                if (su_zero) begin
                    o_time.sec_tens = st_dec;
                    if (st_zero) begin
                        o_time.min_units = mu_dec;
                        if (mu_zero) begin
                            o_time.min_tens = mt_dec;
                        end
                    end
                end
            end
        end else begin
            // lowest pressed button wins
            if (i_item.adjust_mask[0]) begin
                o_time.sec_units = su_inc;
            end else if (i_item.adjust_mask[1]) begin
                o_time.sec_tens = st_inc;
            end else if (i_item.adjust_mask[2]) begin
                o_time.min_units = mu_inc;
            end else if (i_item.adjust_mask[3]) begin
                o_time.min_tens = mt_inc;
            end
        end
    end

endmodule

// ===== rtl/core/bcd_minute_second_timer.sv =====
// MM:SS timer held as four BCD digits, reset to 00:01. Each transaction either
// counts one second up or down (00:00 borrows round to 59:59) or bumps the
// lowest pressed digit by one with wrap. Every transaction returns one result
// with the digits, a zero flag and active-low seven-segment patterns (the
// minute-units pattern lights the separator dot). One transaction per cycle
// unless the output stalls: the step and decode sit in front of a single
// result register, and a new transaction is taken whenever that register is
// empty or is being drained in the same cycle.
module bcd_minute_second_timer
    import bmst_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_result
);

    t_time     r_time;
    t_time     n_time;
    t_out_item r_result;
    t_out_item n_result;
    logic      r_valid;
    logic      accept;

    assign o_stall = r_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    bmst_step u_step (
        .i_time (r_time),
        .i_item (i_item),
        .o_time (n_time)
    );

    always_comb begin
        n_result.sec_units     = n_time.sec_units;
        n_result.sec_tens      = n_time.sec_tens;
        n_result.min_units     = n_time.min_units;
        n_result.min_tens      = n_time.min_tens;
        n_result.at_zero       = (n_time == '0);
        n_result.seg_sec_units = f_seg(n_time.sec_units);
        n_result.seg_sec_tens  = f_seg({1'b0, n_time.sec_tens});
        n_result.seg_min_units = f_seg(n_time.min_units) & SEG_DOT_CLR;
        n_result.seg_min_tens  = f_seg({1'b0, n_time.min_tens});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time  <= '{sec_units: 4'd1, sec_tens: 3'd0, min_units: 4'd0, min_tens: 3'd0};
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_time  <= n_time;
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_digits_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_time.sec_units <= UNITS_MAX && r_time.sec_tens <= TENS_MAX &&
        r_time.min_units <= UNITS_MAX && r_time.min_tens <= TENS_MAX)
        else $error("timer digit out of range");

    a_result_tracks_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.sec_units == r_time.sec_units &&
                     o_result.sec_tens == r_time.sec_tens &&
                     o_result.min_units == r_time.min_units &&
                     o_result.min_tens == r_time.min_tens))
        else $error("held result does not match time");

    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.at_zero == (r_time == '0)))
        else $error("zero flag wrong");

    a_time_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_time))
        else $error("time changed without a transaction");

    a_dot_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_result.seg_min_units[0])
        else $error("separator dot not lit");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb
    import bmst_pkg::*;
();

    localparam int RANDOM_ITEMS = 1530;
    localparam int LIMIT_CYCLES = 100000;
    localparam int UNITS_WRAP   = int'(UNITS_MAX) + 1;
    localparam int TENS_WRAP    = int'(TENS_MAX) + 1;

    // Tracks the MM:SS time and holds the displays still owed by the block.
    class timer_scoreboard;
        t_time       now_time;
        t_out_item   owed_q[$];
        int unsigned mismatches;
        logic [7:0]  glyph [10];

        function new();
            glyph = '{8'h09, 8'hAF, 8'h31, 8'h23, 8'h87, 8'h43, 8'h41, 8'h2F, 8'h01, 8'h07};
            now_time = '0;
            now_time.sec_units = 4'd1;
            mismatches = 0;
        endfunction

        function logic [7:0] glyph_of(int d);
            return (d < 10) ? glyph[d] : SEG_BLANK;
        endfunction

        // returns 1 on carry out
        function bit tick_up(inout int d, input int wrap);
            d = d + 1;
            if (d >= wrap) begin
                d = 0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // returns 1 on borrow
        function bit tick_down(inout int d, input int wrap);
            if (d == 0) begin
                d = wrap - 1;
                return 1'b1;
            end
            d = d - 1;
            return 1'b0;
        endfunction

        function void note_step(t_in_item it);
            int su, st, mu, mt;
            t_out_item disp;
            su = now_time.sec_units;
            st = now_time.sec_tens;
            mu = now_time.min_units;
            mt = now_time.min_tens;
            if (it.opcode == OP_COUNT) begin
                if (it.count_up) begin
                    if (tick_up(su, UNITS_WRAP))
                        if (tick_up(st, TENS_WRAP))
                            if (tick_up(mu, UNITS_WRAP))
                                void'(tick_up(mt, TENS_WRAP));
                end else begin
                    if (tick_down(su, UNITS_WRAP))
                        if (tick_down(st, TENS_WRAP))
                            if (tick_down(mu, UNITS_WRAP))
                                void'(tick_down(mt, TENS_WRAP));
                end
            end else begin
                // lowest pressed button wins
                if (it.adjust_mask[0])
                    void'(tick_up(su, UNITS_WRAP));
                else if (it.adjust_mask[1])
                    void'(tick_up(st, TENS_WRAP));
                else if (it.adjust_mask[2])
                    void'(tick_up(mu, UNITS_WRAP));
                else if (it.adjust_mask[3])
                    void'(tick_up(mt, TENS_WRAP));
            end
            now_time.sec_units = su[3:0];
            now_time.sec_tens  = st[2:0];
            now_time.min_units = mu[3:0];
            now_time.min_tens  = mt[2:0];

            disp.sec_units     = su[3:0];
            disp.sec_tens      = st[2:0];
            disp.min_units     = mu[3:0];
            disp.min_tens      = mt[2:0];
            disp.at_zero       = (su == 0 && st == 0 && mu == 0 && mt == 0);
            disp.seg_sec_units = glyph_of(su);
            disp.seg_sec_tens  = glyph_of(st);
            disp.seg_min_units = glyph_of(mu) & SEG_DOT_CLR;
            disp.seg_min_tens  = glyph_of(mt);
            owed_q.push_back(disp);
        endfunction

        function void compare(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: %s expected %0h got %0h", name, want, got);
            end
        endfunction

        function void check_display(t_out_item got);
            t_out_item want;
            if (owed_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: unexpected result %0h", got);
                return;
            end
            want = owed_q.pop_front();
            compare("sec_units", 8'(want.sec_units), 8'(got.sec_units));
            compare("sec_tens", 8'(want.sec_tens), 8'(got.sec_tens));
            compare("min_units", 8'(want.min_units), 8'(got.min_units));
            compare("min_tens", 8'(want.min_tens), 8'(got.min_tens));
            compare("at_zero", 8'(want.at_zero), 8'(got.at_zero));
            compare("seg_sec_units", want.seg_sec_units, got.seg_sec_units);
            compare("seg_sec_tens", want.seg_sec_tens, got.seg_sec_tens);
            compare("seg_min_units", want.seg_min_units, got.seg_min_units);
            compare("seg_min_tens", want.seg_min_tens, got.seg_min_tens);
        endfunction

        function void close_out();
            if (owed_q.size() != 0) begin
                $display("tb: %0d results never arrived", owed_q.size());
                mismatches += owed_q.size();
            end
        endfunction
    endclass

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_item  = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_result;

    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;

    timer_scoreboard sb;

    bcd_minute_second_timer dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("tb: timeout");
        $display("tb: FAIL");
        $finish;
    end

    always @(negedge i_clk) begin
        i_stall <= rx_idle_on && ($urandom_range(99) < 8);
    end

    // inputs noted before results so a same-edge pair stays in order
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_step(i_item);
            if (o_valid && !i_stall)
                sb.check_display(o_result);
        end
    end

    function automatic t_in_item make_item(logic op, logic up, logic [3:0] mask);
        t_in_item it;
        it.opcode      = op;
        it.count_up    = up;
        it.adjust_mask = mask;
        return it;
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send(input t_in_item it);
        if (tx_idle_on && $urandom_range(99) < 8) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (sb.owed_q.size() != 0);
    endtask

    initial begin
        int  burst_left;
        bit  burst_op;
        bit  burst_up;
        bit  burst_fixed;
        logic [3:0] burst_mask;
        t_in_item it;

        sb = new();
        burst_left = 0;
        burst_op = OP_COUNT;
        burst_up = 1'b1;
        burst_fixed = 1'b0;
        burst_mask = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty press, zero, borrow round, carry round, priorities
        send(make_item(OP_ADJUST, 1'b0, 4'b0000));
        send(make_item(OP_COUNT, 1'b0, 4'b0000));
        send(make_item(OP_COUNT, 1'b0, 4'b1111));
        send(make_item(OP_COUNT, 1'b1, 4'b0000));
        send(make_item(OP_COUNT, 1'b1, 4'b1111));
        send(make_item(OP_ADJUST, 1'b1, 4'b1000));
        send(make_item(OP_ADJUST, 1'b0, 4'b0100));
        send(make_item(OP_ADJUST, 1'b0, 4'b0010));
        send(make_item(OP_ADJUST, 1'b0, 4'b0001));
        send(make_item(OP_ADJUST, 1'b1, 4'b1111));
        send(make_item(OP_ADJUST, 1'b0, 4'b1110));
        send(make_item(OP_ADJUST, 1'b0, 4'b1100));
        send(make_item(OP_ADJUST, 1'b0, 4'b1010));
        repeat (6) send(make_item(OP_ADJUST, 1'b0, 4'b1000));
        send(make_item(OP_COUNT, 1'b0, 4'b0101));
        send(make_item(OP_COUNT, 1'b1, 4'b1010));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case (n)
                0: begin
                    tx_idle_on = 1'b1;
                    rx_idle_on = 1'b1;
                end
                500: begin
                    tx_idle_on = 1'b0;
                    rx_idle_on = 1'b0;
                end
                850: begin
                    tx_idle_on = 1'b1;
                    rx_idle_on = 1'b1;
                end
                1100: drain();
                default: ;
            endcase

            if (burst_left == 0) begin
                burst_op    = ($urandom_range(99) < 65) ? OP_COUNT : OP_ADJUST;
                burst_up    = 1'($urandom_range(1));
                burst_fixed = 1'($urandom_range(1));
                burst_mask  = 4'($urandom_range(15));
                burst_left  = (burst_op == OP_COUNT) ? $urandom_range(1, 90)
                                                     : $urandom_range(1, 12);
            end
            burst_left--;

            // the odd stray transaction breaks up the bursts
            if ($urandom_range(99) < 10)
                it = make_item(1'($urandom_range(1)), 1'($urandom_range(1)),
                               4'($urandom_range(15)));
            else if (burst_op == OP_COUNT)
                it = make_item(OP_COUNT, burst_up, 4'($urandom_range(15)));
            else
                it = make_item(OP_ADJUST, 1'($urandom_range(1)),
                               burst_fixed ? burst_mask : 4'($urandom_range(15)));
            send(it);
        end

        drain();
        repeat (4) @(negedge i_clk);
        sb.close_out();
        if (sb.mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
